### sv/smpq_pkg.sv
// Shared types and constants for the sorted min-priority queue.
package smpq_pkg;

  // Width of one stored value.
  localparam int DATA_W = 32;

  // Width of the count field in a result word.
  localparam int OUT_CNT_W = 5;

  // Command codes of an input word.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Status codes of a result word.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Control broadcast to every cell for one accepted word.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] val;
  } cell_ctl_t;

  // What a cell hands to its right-hand neighbor.
  typedef struct packed {
    logic                     keep;
    logic signed [DATA_W-1:0] data;
  } cell_link_t;

endpackage

### sv/smpq_cell.sv
// One cell of the sorted chain: holds a single entry and shifts with its neighbors.
module smpq_cell
  import smpq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [CNT_W-1:0]         count,
  input  cell_link_t               left,
  input  logic signed [DATA_W-1:0] right_data,
  output cell_link_t               link
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     occ;
  logic                     keep;

  // An occupied entry that is not greater than the new value stays put.
  assign occ  = count > CNT_W'(IDX);
  assign keep = occ && (data_r <= ctl.val);

  // Insert: stay, take the new value, or take the left entry.
  // Remove: take the right entry so everything moves toward the head.
  always_comb begin
    priority if (ctl.ins) begin
      if (keep) begin
        data_nxt = data_r;
      end else if (left.keep) begin
        data_nxt = ctl.val;
      end else begin
        data_nxt = left.data;
      end
    end else if (ctl.rem) begin
      data_nxt = right_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign link.keep = keep;
  assign link.data = data_r;

endmodule

### sv/sorted_min_priority_queue.sv
// Top level of the sorted min-priority queue built as a chain of cells.
//
// Usage:
//   Command channel: drive start high with in_cmd and in_value for one cycle.
//   A word is accepted at a rising edge with start high and busy low. busy
//   stays low, so a new word may be given in every cycle.
//   in_cmd selects insert of in_value or removal of the smallest entry.
//   Result channel: out_strobe is high for exactly one cycle, the cycle right
//   after the accepting edge, with out_status, out_removed_value and
//   out_entry_count. The receiver cannot stall; it must take each result.
//   Throughput is one word per cycle. Every cell
//   compares its own entry against the new value in the same cycle and the
//   whole chain shifts by one place in that cycle, so no loop spans cycles.
//   Overflow on a full queue and underflow on an empty one leave the entries
//   and count as they were. Reset (rst_n low, synchronous) clears the count
//   and the strobe; entries above the count are never read, so the cells
//   need no clearing pass.
module sorted_min_priority_queue
  import smpq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_cmd,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_strobe,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic [OUT_CNT_W-1:0]     out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                     accept;
  logic                     full;
  logic                     empty;
  cell_ctl_t                ctl;
  cell_link_t               links [CAPACITY];
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  status_t                  status_nxt;
  logic signed [DATA_W-1:0] removed_nxt;
  logic                     strobe_r;
  status_t                  status_r;
  logic signed [DATA_W-1:0] removed_r;
  logic [OUT_CNT_W-1:0]     entry_count_r;

  // The chain takes each word straight away, so the block never holds off start.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = count_r == CNT_W'(CAPACITY);
  assign empty  = count_r == '0;

  // Decode the word into the broadcast control for the chain.
  always_comb begin
    ctl.ins     = accept && (in_cmd == CMD_INSERT) && !full;
    ctl.rem     = accept && (in_cmd == CMD_REMOVE) && !empty;
    ctl.val     = in_value;
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    removed_nxt = '0;
    if (in_cmd == CMD_INSERT) begin
      if (full) begin
        status_nxt = ST_OVERFLOW;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_UNDERFLOW;
      end else begin
        count_nxt   = count_r - CNT_W'(1);
        removed_nxt = links[0].data;
      end
    end
  end

  // The chain of cells, entry 0 at the head holds the smallest value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t               left_in;
    logic signed [DATA_W-1:0] right_in;

    if (i == 0) begin : g_head
      assign left_in.keep = 1'b1;
      assign left_in.data = '0;
    end else begin : g_body
      assign left_in = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_inner
      assign right_in = links[i+1].data;
    end

    smpq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .left       (left_in),
      .right_data (right_in),
      .link       (links[i])
    );
  end

  // Count and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result word registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      removed_r     <= removed_nxt;
      entry_count_r <= OUT_CNT_W'(count_nxt);
    end
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_entry_count   = entry_count_r;

`ifndef SYNTHESIS
  // The count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // Every accepted word yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && accept) |=> out_strobe)
    else $error("accepted word gave no result");

  // Overflow is only reported with a full queue and a zero value.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_OVERFLOW) |-> (full && out_removed_value == '0))
    else $error("overflow reported while not full");

  // Underflow is only reported with an empty queue and a zero value.
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_UNDERFLOW) |-> (empty && out_removed_value == '0))
    else $error("underflow reported while not empty");
`endif

endmodule
